FILE: rtl/integer_to_radix_string_top_assert.svh
// Assertion macros shared by the checker. Each expands to one labeled
// concurrent assertion clocked on clk and held off while rst_n is low.
`ifndef INTEGER_TO_RADIX_STRING_TOP_ASSERT_SVH
`define INTEGER_TO_RADIX_STRING_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITOA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int RADIX_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int RADIX_MIN     = 2;
  localparam int RADIX_MAX     = 35;
  localparam int RADIX_RESET   = 10;

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_WIDTH / BITS_PER_STEP;
  localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CNT_W         = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W         = $clog2(VALUE_WIDTH);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;

  typedef enum logic [1:0] {
    SEL_SIGN,
    SEL_DIGIT,
    SEL_NUL
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      div;
    logic      emit;
    char_sel_t sel;
  } itoa_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic digit_done;
    logic quot_zero;
    logic neg;
    logic cnt_one;
    logic out_free;
  } itoa_stat_t;

  // Digit value to its lower-case ASCII glyph.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < RADIX_W'(10)) begin
      digit_char = dx + 7'h30;
    end else begin
      digit_char = dx + 7'h57;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/itoa_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface itoa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [itoa_pkg::VALUE_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface itoa_out_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::CHAR_W-1:0]   text_char;
  logic                          last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

FILE: rtl/itoa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module itoa_datapath (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire itoa_pkg::itoa_cmd_t                cmd,
  output itoa_pkg::itoa_stat_t                    stat,
  input  wire signed [itoa_pkg::VALUE_WIDTH-1:0]  number,
  input  wire                                     cfg_wr_en,
  input  wire        [itoa_pkg::RADIX_W-1:0]      cfg_wr_data,
  output logic                                    out_valid,
  output logic       [itoa_pkg::CHAR_W-1:0]       out_char,
  output logic                                    out_last,
  input  wire                                     out_ready
);
  import itoa_pkg::*;

  logic [RADIX_W-1:0]     radix_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [VALUE_WIDTH-1:0] mag_nxt;
  logic [RADIX_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     rem_nxt;
  logic [RADIX_W:0]       div_trial;
  logic                   div_qbit;
  logic [STEP_W-1:0]      div_step_r;
  logic                   neg_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_dec;
  logic [RADIX_W-1:0]     digits_r [VALUE_WIDTH];
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic [VALUE_WIDTH-1:0] num_u;
  logic [VALUE_WIDTH-1:0] num_abs;
  logic                   last_step;

  assign num_u     = number;
  assign num_abs   = num_u[VALUE_WIDTH-1] ? (~num_u + 1'b1) : num_u;
  assign last_step = (div_step_r == STEP_W'(DIV_STEPS - 1));
  assign cnt_dec   = cnt_r - 1'b1;

  // Restoring long division, a slice of quotient bits per cycle. The
  // quotient shifts into the magnitude register as the dividend shifts out.
  always_comb begin
    rem_nxt   = (div_step_r == '0) ? '0 : rem_r;
    mag_nxt   = mag_r;
    div_trial = '0;
    div_qbit  = 1'b0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      div_trial = {rem_nxt, mag_nxt[VALUE_WIDTH-1]};
      div_qbit  = (div_trial >= {1'b0, radix_r});
      if (div_qbit) begin
        rem_nxt = RADIX_W'(div_trial - {1'b0, radix_r});
      end else begin
        rem_nxt = div_trial[RADIX_W-1:0];
      end
      mag_nxt = {mag_nxt[VALUE_WIDTH-2:0], div_qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_W'(RADIX_RESET);
      div_step_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        div_step_r <= '0;
        cnt_r      <= '0;
      end else if (cmd.div) begin
        div_step_r <= last_step ? '0 : div_step_r + 1'b1;
        if (last_step) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (cmd.emit && cmd.sel == SEL_DIGIT) begin
        cnt_r <= cnt_dec;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= num_u[VALUE_WIDTH-1];
      mag_r <= num_abs;
    end else if (cmd.div) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
      if (last_step) begin
        digits_r[cnt_r[IDX_W-1:0]] <= rem_nxt;
      end
    end
    if (cmd.emit) begin
      unique case (cmd.sel)
        SEL_SIGN:  out_char_r <= CHAR_MINUS;
        SEL_DIGIT: out_char_r <= digit_char(digits_r[cnt_dec[IDX_W-1:0]]);
        default:   out_char_r <= CHAR_NUL;
      endcase
      out_last_r <= (cmd.sel == SEL_NUL);
    end
  end

  assign stat.radix_ok   = (radix_r >= RADIX_W'(RADIX_MIN)) && (radix_r <= RADIX_W'(RADIX_MAX));
  assign stat.digit_done = last_step;
  assign stat.quot_zero  = (mag_nxt == '0);
  assign stat.neg        = neg_r;
  assign stat.cnt_one    = (cnt_r == CNT_W'(1));
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/itoa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module itoa_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire itoa_pkg::itoa_stat_t stat,
  output itoa_pkg::itoa_cmd_t   cmd
);
  import itoa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIVIDE = 5'b00010,
    ST_SIGN   = 5'b00100,
    ST_DIGITS = 5'b01000,
    ST_NUL    = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.div   = 1'b0;
    cmd.emit  = 1'b0;
    cmd.sel   = SEL_NUL;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.radix_ok ? ST_DIVIDE : ST_NUL;
        end
      end
      ST_DIVIDE: begin
        cmd.div = 1'b1;
        if (stat.digit_done && stat.quot_zero) begin
          state_nxt = stat.neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        cmd.sel = SEL_SIGN;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        // Digits were stored least significant first, so they leave in reverse.
        cmd.sel = SEL_DIGIT;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.cnt_one) begin
            state_nxt = ST_NUL;
          end
        end
      end
      ST_NUL: begin
        cmd.sel = SEL_NUL;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/integer_to_radix_string_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload                      Transfer
// in_ch     in         number (32-bit signed)       valid && ready
// out_ch    out        text_char (7), last_char (1) valid && ready
// cfg       in         cfg_wr_data = radix (6)      cfg_wr_en
//
// An item is accepted, then divided digit by digit (8 quotient bits a cycle
// over the 32-bit magnitude), then sent one character per cycle while the
// output is not stalled: a minus sign if negative, the digits, then a NUL.
// An out-of-range radix sends only the NUL.
// A stalled output holds the character register and pauses the sequencer.
// Synchronous active-low reset sets the radix to 10 and empties the output.
module integer_to_radix_string_top (
  input  wire                                clk,
  input  wire                                rst_n,
  itoa_in_if.sink                            in_ch,
  itoa_out_if.source                         out_ch,
  input  wire                                cfg_wr_en,
  input  wire [itoa_pkg::RADIX_W-1:0]        cfg_wr_data
);
  import itoa_pkg::*;

  itoa_cmd_t  cmd;
  itoa_stat_t stat;
  logic       ctl_in_ready;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itoa_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .number      (in_ch.number),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_ch.valid),
    .out_char    (out_ch.text_char),
    .out_last    (out_ch.last_char),
    .out_ready   (out_ch.ready)
  );

  assign in_ch.ready = ctl_in_ready;

endmodule
`default_nettype wire

FILE: rtl/itoa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_string_top_assert.svh"
module itoa_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [itoa_pkg::CHAR_W-1:0]   text_char,
  input wire                          last_char
);
  import itoa_pkg::*;

  // One item at a time: the block is busy right after taking one.
  `ITOA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted item while busy")

  // Only the terminator is NUL, and it alone carries the last mark.
  `ITOA_ASSERT_SAME(a_last_is_nul, out_valid, last_char == (text_char == CHAR_NUL), "last mark mismatch")

  `ITOA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(text_char) && $stable(last_char), "stalled output changed")

endmodule

bind integer_to_radix_string_top itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .text_char (out_ch.text_char),
  .last_char (out_ch.last_char)
);
`default_nettype wire
